FILE: hw/rtl/erb_pkg.sv
// ----------------------------------------------------------------------------
// erb_pkg: shared types, codes and helpers for the 2D rigid body integrator
// Holds the sequencer and serial ALU state types, command codes and the
// signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erb_pkg;

  // Q16.16 format
  localparam int unsigned WordW  = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned MassW  = 31;
  localparam int unsigned WideW  = 50;  // room for any exact sum or product slice

  // Serial ALU iteration counts (one bit per cycle)
  localparam int unsigned MulCycles = WordW;
  localparam int unsigned DivCycles = WordW + FracW;
  localparam int unsigned CntW      = 6;

  // Command codes
  localparam logic [2:0] FnIntegrate  = 3'd0;
  localparam logic [2:0] FnImpulse    = 3'd1;
  localparam logic [2:0] FnAddSteady  = 3'd2;
  localparam logic [2:0] FnAddFrame   = 3'd3;
  localparam logic [2:0] FnSetVel     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] RegMass   = 2'd0;
  localparam logic [1:0] RegGScale = 2'd1;
  localparam logic [1:0] RegGravX  = 2'd2;
  localparam logic [1:0] RegGravY  = 2'd3;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIN
  } alu_state_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SIMPLE,
    T_START,
    T_WAIT,
    T_OUT
  } top_state_e;

  // Micro-steps of the integrate and impulse commands
  typedef enum logic [3:0] {
    ST_GM,
    ST_GX,
    ST_GY,
    ST_AX,
    ST_AY,
    ST_VX,
    ST_VY,
    ST_PX,
    ST_PY,
    ST_IX,
    ST_IY
  } step_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

  // Clamp to the signed 32-bit range; returns {clamped, value}
  function automatic logic [WordW:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    logic [WordW:0] r;
    hi = WideW'(signed'(33'sh0_7FFF_FFFF));
    lo = WideW'(signed'(33'sh1_8000_0000));
    if (v > hi) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < lo) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[WordW-1:0]};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/euler_rigid_body_2d.sv
// ----------------------------------------------------------------------------
// euler_rigid_body_2d: semi-implicit Euler integrator for one 2D point body
// Q16.16 velocity and force state; integrate, impulse, force and set-velocity
// commands, with saturation of every stored and returned value.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser[2:0] func; tdata vec_x, vec_y, pos_x, pos_y, step_time
//  m_axis    out        tuser[0] saturated; tdata result_x, result_y, new_pos_x, new_pos_y
//  cfg       in         write enable, 2-bit register index, 32-bit data
//
//  Integrate runs 7 bit-serial ALU multiplies and 2 divides; impulse runs
//  2 divides; other commands go through the simple path to the output.
//  Reset clears velocity and forces and loads mass 1.0 and gravity scale 1.0.
//  A finished result waits in the output register; a stalled output holds
//  the next result in the sequencer until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_rigid_body_2d import erb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // vec_x, vec_y, pos_x, pos_y, step_time, pad
  input  logic [2:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // result_x, result_y, new_pos_x, new_pos_y
  output logic         m_axis_tuser,  // saturated
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  top_state_e state_q, state_d;
  step_e      step_q;

  logic [MassW-1:0] mass_q;
  logic [31:0] gscale_q, grav_x_q, grav_y_q;
  logic [31:0] vel_x_q, vel_y_q, sf_x_q, sf_y_q, ff_x_q, ff_y_q;
  logic [2:0]  func_q;
  logic [31:0] vec_x_q, vec_y_q, pos_x_q, pos_y_q;
  logic [MassW-1:0] dt_q;
  logic [31:0] gm_q, tmp_x_q, tmp_y_q;
  logic [31:0] res_x_q, res_y_q, npos_x_q, npos_y_q;
  logic        sat_q;
  logic [127:0] out_data_q;
  logic        out_user_q, out_valid_q;

  logic        in_acc, out_free;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [31:0] alu_a, alu_b, alu_res;
  logic [31:0] mass_eff;
  logic [31:0] add_b, add_c;
  logic [WordW:0] step_s;
  logic [WordW:0] simp_x, simp_y;
  logic        last_step;
  step_e       next_step;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign mass_eff = (mass_q == '0) ? 32'd1 : {1'b0, mass_q};

  erb_serial_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  // Operand selection per step
  always_comb begin
    alu_a = tmp_x_q;
    alu_b = {1'b0, dt_q};
    alu_req.start = (state_q == T_START);
    alu_req.op = ALU_MUL;
    unique case (step_q)
      ST_GM: begin alu_a = gscale_q; alu_b = {1'b0, mass_q}; end
      ST_GX: begin alu_a = grav_x_q; alu_b = gm_q; end
      ST_GY: begin alu_a = grav_y_q; alu_b = gm_q; end
      ST_AX: begin alu_a = tmp_x_q; alu_b = mass_eff; alu_req.op = ALU_DIV; end
      ST_AY: begin alu_a = tmp_y_q; alu_b = mass_eff; alu_req.op = ALU_DIV; end
      ST_VX: alu_a = tmp_x_q;
      ST_VY: alu_a = tmp_y_q;
      ST_PX: alu_a = vel_x_q;
      ST_PY: alu_a = vel_y_q;
      ST_IX: begin alu_a = vec_x_q; alu_b = mass_eff; alu_req.op = ALU_DIV; end
      ST_IY: begin alu_a = vec_y_q; alu_b = mass_eff; alu_req.op = ALU_DIV; end
      default: ;
    endcase
  end

  // Post-add of the ALU result per step
  always_comb begin
    add_b = '0;
    add_c = '0;
    unique case (step_q)
      ST_GX: begin add_b = sf_x_q; add_c = ff_x_q; end
      ST_GY: begin add_b = sf_y_q; add_c = ff_y_q; end
      ST_VX, ST_IX: add_b = vel_x_q;
      ST_VY, ST_IY: add_b = vel_y_q;
      ST_PX: add_b = pos_x_q;
      ST_PY: add_b = pos_y_q;
      default: ;
    endcase
    step_s = sat32(WideW'($signed(alu_res)) + WideW'($signed(add_b))
                   + WideW'($signed(add_c)));
  end

  // Step order
  always_comb begin
    last_step = 1'b0;
    next_step = step_q;
    unique case (step_q)
      ST_GM: next_step = ST_GX;
      ST_GX: next_step = ST_GY;
      ST_GY: next_step = ST_AX;
      ST_AX: next_step = ST_AY;
      ST_AY: next_step = ST_VX;
      ST_VX: next_step = ST_VY;
      ST_VY: next_step = ST_PX;
      ST_PX: next_step = ST_PY;
      ST_IX: next_step = ST_IY;
      ST_PY, ST_IY: last_step = 1'b1;
      default: last_step = 1'b1;
    endcase
  end

  // Simple commands: add to a force or set the velocity
  always_comb begin
    simp_x = '0;
    simp_y = '0;
    case (func_q)
      FnAddSteady: begin
        simp_x = sat32(WideW'($signed(sf_x_q)) + WideW'($signed(vec_x_q)));
        simp_y = sat32(WideW'($signed(sf_y_q)) + WideW'($signed(vec_y_q)));
      end
      FnAddFrame: begin
        simp_x = sat32(WideW'($signed(ff_x_q)) + WideW'($signed(vec_x_q)));
        simp_y = sat32(WideW'($signed(ff_y_q)) + WideW'($signed(vec_y_q)));
      end
      FnSetVel: begin
        simp_x = sat32(WideW'($signed(vec_x_q)) - WideW'($signed(vel_x_q)));
        simp_y = sat32(WideW'($signed(vec_y_q)) - WideW'($signed(vel_y_q)));
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == FnIntegrate || s_axis_tuser == FnImpulse) begin
            state_d = T_START;
          end else begin
            state_d = T_SIMPLE;
          end
        end
      end
      T_SIMPLE: state_d = T_OUT;
      T_START:  state_d = T_WAIT;
      T_WAIT:   if (alu_rsp.done) state_d = last_step ? T_OUT : T_START;
      T_OUT:    if (out_free) state_d = T_IDLE;
      default:  state_d = T_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == T_IDLE);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_data_q;
    m_axis_tuser  = out_user_q;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      mass_q      <= MassW'(32'h0001_0000);
      gscale_q    <= 32'h0001_0000;
      grav_x_q    <= '0;
      grav_y_q    <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      sf_x_q      <= '0;
      sf_y_q      <= '0;
      ff_x_q      <= '0;
      ff_y_q      <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegMass:   mass_q   <= cfg_wdata_i[MassW-1:0];
          RegGScale: gscale_q <= cfg_wdata_i;
          RegGravX:  grav_x_q <= cfg_wdata_i;
          RegGravY:  grav_y_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (state_q == T_SIMPLE) begin
        case (func_q)
          FnAddSteady: begin sf_x_q <= simp_x[31:0]; sf_y_q <= simp_y[31:0]; end
          FnAddFrame:  begin ff_x_q <= simp_x[31:0]; ff_y_q <= simp_y[31:0]; end
          FnSetVel:    begin vel_x_q <= vec_x_q; vel_y_q <= vec_y_q; end
          default: ;
        endcase
      end

      if (state_q == T_WAIT && alu_rsp.done) begin
        case (step_q)
          ST_VX, ST_IX: vel_x_q <= step_s[31:0];
          ST_VY, ST_IY: vel_y_q <= step_s[31:0];
          ST_PY: begin ff_x_q <= '0; ff_y_q <= '0; end
          default: ;
        endcase
      end

      if (state_q == T_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, scratch and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= s_axis_tuser;
      vec_x_q <= s_axis_tdata[31:0];
      vec_y_q <= s_axis_tdata[63:32];
      pos_x_q <= s_axis_tdata[95:64];
      pos_y_q <= s_axis_tdata[127:96];
      dt_q    <= s_axis_tdata[158:128];
      sat_q   <= 1'b0;
      step_q  <= (s_axis_tuser == FnImpulse) ? ST_IX : ST_GM;
    end

    if (state_q == T_SIMPLE) begin
      npos_x_q <= pos_x_q;
      npos_y_q <= pos_y_q;
      res_x_q  <= simp_x[31:0];
      res_y_q  <= simp_y[31:0];
      sat_q    <= simp_x[WordW] | simp_y[WordW];
      if (func_q == FnSetVel) begin
        // nothing extra: result is the velocity change
      end
    end

    if (state_q == T_WAIT && alu_rsp.done) begin
      sat_q <= sat_q | alu_rsp.sat | step_s[WordW];
      if (!last_step) step_q <= next_step;
      case (step_q)
        ST_GM: gm_q <= step_s[31:0];
        ST_GX, ST_AX: tmp_x_q <= step_s[31:0];
        ST_GY, ST_AY: tmp_y_q <= step_s[31:0];
        ST_PX: npos_x_q <= step_s[31:0];
        ST_PY: begin
          npos_y_q <= step_s[31:0];
          res_x_q  <= vel_x_q;
          res_y_q  <= vel_y_q;
        end
        ST_IY: begin
          npos_x_q <= pos_x_q;
          npos_y_q <= pos_y_q;
          res_x_q  <= vel_x_q;
          res_y_q  <= step_s[31:0];
        end
        default: ;
      endcase
    end

    if (state_q == T_OUT && out_free) begin
      out_data_q <= {npos_y_q, npos_x_q, res_y_q, res_x_q};
      out_user_q <= sat_q;
    end
  end

  // ALU only finishes while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == T_WAIT))
    else $error("ALU finished outside wait state");

  // An accepted item always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != T_IDLE))
    else $error("accepted item left sequencer idle");

  // A result only leaves the output register through a handshake
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(m_axis_tready))
    else $error("result dropped without transaction");

  // Output register is never overwritten while holding an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_OUT && out_valid_q && !m_axis_tready) |=> (state_q == T_OUT))
    else $error("sequencer left output state while result stalled");

endmodule

FILE: hw/rtl/erb_serial_alu.sv
// ----------------------------------------------------------------------------
// erb_serial_alu: bit-serial Q16.16 multiplier and mass divider
// Multiply: shift-add on magnitudes, floor by 2^16, saturate.
// Divide: restoring division of a*2^16 by mass, floored, saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erb_serial_alu import erb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alu_req_t    req_i,
  input  logic [31:0] a_i,    // signed operand / dividend
  input  logic [31:0] b_i,    // signed multiplier or unsigned divisor
  output alu_rsp_t    rsp_o,
  output logic [31:0] res_o
);

  alu_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  alu_op_e op_q;
  logic neg_q;
  logic [32:0] acc_hi_q;
  logic [31:0] acc_lo_q;
  logic [31:0] ma_q;
  logic [47:0] num_q;
  logic [31:0] rem_q;

  logic [31:0] mag_a, mag_b;
  logic [32:0] mul_sum;
  logic [31:0] trial;
  logic        fits;
  logic signed [64:0] prod_s;
  logic signed [48:0] prod_fl;
  logic [48:0] quo_m;
  logic signed [WideW-1:0] fin_v;
  logic [WordW:0] fin_s;

  assign mag_a = a_i[31] ? (32'd0 - a_i) : a_i;
  assign mag_b = b_i[31] ? (32'd0 - b_i) : b_i;

  // Shift-add step and restoring-divide step
  assign mul_sum = acc_hi_q + (acc_lo_q[0] ? {1'b0, ma_q} : 33'd0);
  assign trial   = {rem_q[30:0], num_q[47]};
  assign fits    = (trial >= ma_q);

  // Final sign, floor and clamp
  always_comb begin
    prod_s  = neg_q ? -$signed({1'b0, acc_hi_q[31:0], acc_lo_q})
                    :  $signed({1'b0, acc_hi_q[31:0], acc_lo_q});
    prod_fl = 49'(prod_s >>> FracW);
    // negative quotient rounds away from zero when a remainder is left
    quo_m   = {1'b0, num_q} + {48'd0, (neg_q && (rem_q != 32'd0))};
    if (op_q == ALU_MUL) begin
      fin_v = WideW'(prod_fl);
    end else begin
      fin_v = neg_q ? -$signed({1'b0, quo_m}) : $signed({1'b0, quo_m});
    end
    fin_s = sat32(fin_v);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: if (req_i.start) state_d = (req_i.op == ALU_MUL) ? A_MUL : A_DIV;
      A_MUL:  if (cnt_q == '0) state_d = A_FIN;
      A_DIV:  if (cnt_q == '0) state_d = A_FIN;
      A_FIN:  state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp_o.done = (state_q == A_FIN);
    rsp_o.sat  = (state_q == A_FIN) && fin_s[WordW];
    res_o      = fin_s[WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == A_IDLE && req_i.start) begin
        cnt_q <= (req_i.op == ALU_MUL) ? CntW'(MulCycles - 1) : CntW'(DivCycles - 1);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_q <= req_i.op;
          if (req_i.op == ALU_MUL) begin
            neg_q    <= a_i[31] ^ b_i[31];
            ma_q     <= mag_a;
            acc_hi_q <= '0;
            acc_lo_q <= mag_b;
          end else begin
            neg_q <= a_i[31];
            ma_q  <= b_i;
            num_q <= {mag_a, 16'd0};
            rem_q <= '0;
          end
        end
      end
      A_MUL: begin
        acc_hi_q <= {1'b0, mul_sum[32:1]};
        acc_lo_q <= {mul_sum[0], acc_lo_q[31:1]};
      end
      A_DIV: begin
        rem_q <= fits ? (trial - ma_q) : trial;
        num_q <= {num_q[46:0], fits};
      end
      default: ;
    endcase
  end

endmodule
